>>> src/mtep_pkg.sv
// Shared types and constants for the MIDI track event parser.
package mtep_pkg;

	typedef struct packed {
		logic [7:0] track_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] event_tick;
		logic [7:0]  status_byte;
		logic [7:0]  first_data;
		logic [7:0]  second_data;
		logic [1:0]  data_count;
		logic [23:0] tempo_value;
		logic [3:0]  error_code;
		logic [63:0] channel_digest;
		logic [63:0] tempo_digest;
		logic        last_of_run;
	} out_item_t;

	// Hash unit request from sequencer
	typedef struct packed {
		logic       start;
		logic       sel_tempo;
		logic [7:0] data;
	} hash_req_t;

	localparam logic [63:0] HASH_SEED = 64'hcbf29ce484222325;
	localparam logic [63:0] FNV_MUL   = 64'h00000100000001b3;

	localparam logic [3:0] K_CHANNEL = 4'd0;
	localparam logic [3:0] K_TEMPO   = 4'd1;
	localparam logic [3:0] K_END     = 4'd2;
	localparam logic [3:0] K_LSTART  = 4'd3;
	localparam logic [3:0] K_LEND    = 4'd4;
	localparam logic [3:0] K_LCOUNT  = 4'd5;
	localparam logic [3:0] K_HOOK    = 4'd6;
	localparam logic [3:0] K_ERROR   = 4'd7;
	localparam logic [3:0] K_DONE    = 4'd8;

	localparam logic [3:0] E_AFTER_END  = 4'd1;
	localparam logic [3:0] E_DELTA      = 4'd2;
	localparam logic [3:0] E_EVENT      = 4'd3;
	localparam logic [3:0] E_META_TYPE  = 4'd4;
	localparam logic [3:0] E_META       = 4'd5;
	localparam logic [3:0] E_SYSEX      = 4'd6;
	localparam logic [3:0] E_CHANNEL    = 4'd7;
	localparam logic [3:0] E_NO_STATUS  = 4'd8;
	localparam logic [3:0] E_NO_END     = 4'd9;

	localparam logic [3:0] PH_DELTA      = 4'd0;
	localparam logic [3:0] PH_DELTA_MORE = 4'd1;
	localparam logic [3:0] PH_EVENT      = 4'd2;
	localparam logic [3:0] PH_META_TYPE  = 4'd3;
	localparam logic [3:0] PH_META_LEN   = 4'd4;
	localparam logic [3:0] PH_META_BODY  = 4'd5;
	localparam logic [3:0] PH_SYSEX_LEN  = 4'd6;
	localparam logic [3:0] PH_SYSEX_BODY = 4'd7;
	localparam logic [3:0] PH_CH_DATA    = 4'd8;

endpackage

>>> src/mtep_hash.sv
// Shared FNV-1a round unit holding both digests; a new byte is taken only while it is not busy.
module mtep_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear,
	input  mtep_pkg::hash_req_t req,
	output logic                busy,
	output logic [63:0]         channel_digest,
	output logic [63:0]         tempo_digest
);

	logic [63:0] ch_q, tp_q, x_q, p_lo_q, p_hi_q;
	logic [1:0]  step_q;
	logic        sel_q;
	logic [63:0] src;

	assign src = req.sel_tempo ? tp_q : ch_q;
	assign busy = (step_q != 2'd0);
	assign channel_digest = ch_q;
	assign tempo_digest = tp_q;

	// Step 1: xor; step 2: x times 0x1b3 and x shifted by 40; step 3: combine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q   <= mtep_pkg::HASH_SEED;
			tp_q   <= mtep_pkg::HASH_SEED;
			step_q <= 2'd0;
			sel_q  <= 1'b0;
			x_q    <= '0;
			p_lo_q <= '0;
			p_hi_q <= '0;
		end else if (clear) begin
			ch_q   <= mtep_pkg::HASH_SEED;
			tp_q   <= mtep_pkg::HASH_SEED;
			step_q <= 2'd0;
		end else begin
			case (step_q)
				2'd0: begin
					if (req.start) begin
						x_q    <= src ^ {56'd0, req.data};
						sel_q  <= req.sel_tempo;
						step_q <= 2'd1;
					end
				end
				2'd1: begin
					// x * 0x1b3 plus x << 40 (FNV prime = 2^40 + 0x1b3)
					p_lo_q <= x_q * 9'h1b3;
					p_hi_q <= {x_q[23:0], 40'd0};
					step_q <= 2'd2;
				end
				default: begin
					if (sel_q) tp_q <= p_lo_q + p_hi_q;
					else ch_q <= p_lo_q + p_hi_q;
					step_q <= 2'd0;
				end
			endcase
		end
	end

endmodule

>>> src/midi_track_event_parser.sv
// Top level: byte parser, hashing sequencer and two-entry result queue.
// One track byte is taken per transfer. A byte that produces no result frees the
// input for the next cycle; a byte with results but no hashing holds it until its
// results are taken. A tempo event takes 7 hash rounds and a channel event 6 (one
// data byte) or 7, run one after another in the shared FNV multiply unit before
// the results are offered. A final byte arriving after an error passes through a
// wait state while the digests are cleared. Results (at most two per byte) are
// held in a small output queue and delivered one per transfer; in_ready stays
// low until they are all taken.
module midi_track_event_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mtep_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mtep_pkg::out_item_t  out_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HASH = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_EMIT = 3'd3;

	logic [2:0]  state_q;
	logic [7:0]  rs_q;
	logic [31:0] tick_q, len_q, skip_q;
	logic [3:0]  ph_q;
	logic [7:0]  meta_q;
	logic [23:0] pay_q;
	logic [7:0]  held_q;
	logic        ended_q, err_q;

	// Pending results from the current byte
	mtep_pkg::out_item_t r0_q, r1_q;
	logic [1:0]  cnt_q;
	logic        last_q;
	logic [55:0] hbytes_q;
	logic [2:0]  hleft_q;
	logic        hsel_q;

	mtep_pkg::hash_req_t hreq;
	logic        hbusy, hclear;
	logic [63:0] ch_dig, tp_dig;

	mtep_hash u_hash (
		.clk(clk), .arst_n(arst_n), .clear(hclear), .req(hreq),
		.busy(hbusy), .channel_digest(ch_dig), .tempo_digest(tp_dig)
	);

	// Next-state parse of one byte
	logic [7:0]  b;
	logic [3:0]  n_ph;
	logic [7:0]  n_rs, n_meta, n_held;
	logic [31:0] n_tick, n_len, n_skip, lacc;
	logic [23:0] n_pay;
	logic        n_ended, ev, ev_tempo, erf;
	logic [3:0]  ecode, ekind;
	logic [7:0]  ch_st, ch_a, ch_b;
	logic [1:0]  ch_nd;
	logic [3:0]  fin_ph;
	logic        is_meta, is_sysex, one_st, one_rs;

	always_comb begin
		b = in_data.track_byte;
		n_ph = ph_q; n_rs = rs_q; n_meta = meta_q; n_held = held_q;
		n_tick = tick_q; n_len = len_q; n_skip = skip_q; n_pay = pay_q;
		n_ended = ended_q; ev = 1'b0; ev_tempo = 1'b0; erf = 1'b0;
		ecode = 4'd0; ekind = mtep_pkg::K_CHANNEL;
		ch_st = rs_q; ch_a = 8'd0; ch_b = 8'd0; ch_nd = 2'd0;
		lacc = {len_q[24:0], b[6:0]};
		is_meta = (rs_q == 8'hFF);
		is_sysex = (rs_q == 8'hF0) || (rs_q == 8'hF7);
		one_st = (b[7:4] == 4'hC) || (b[7:4] == 4'hD);
		one_rs = (rs_q[7:4] == 4'hC) || (rs_q[7:4] == 4'hD);
		case (ph_q)
			mtep_pkg::PH_DELTA, mtep_pkg::PH_DELTA_MORE: begin
				if (ph_q == mtep_pkg::PH_DELTA && ended_q) begin
					erf = 1'b1; ecode = mtep_pkg::E_AFTER_END;
				end else begin
					n_len = (ph_q == mtep_pkg::PH_DELTA) ? {25'd0, b[6:0]} : lacc;
					if (b[7]) n_ph = mtep_pkg::PH_DELTA_MORE;
					else begin
						n_tick = tick_q + n_len;
						n_ph = mtep_pkg::PH_EVENT;
					end
				end
			end
			mtep_pkg::PH_EVENT: begin
				n_len = 32'd0;
				if (b[7]) begin
					n_rs = b;
					if (b == 8'hFF) n_ph = mtep_pkg::PH_META_TYPE;
					else if (b == 8'hF0 || b == 8'hF7) n_ph = mtep_pkg::PH_SYSEX_LEN;
					else begin
						n_ph = mtep_pkg::PH_CH_DATA;
						n_skip = one_st ? 32'd1 : 32'd2;
					end
				end else if (is_meta) begin
					n_meta = b; n_ph = mtep_pkg::PH_META_LEN;
				end else if (is_sysex) begin
					// First byte of sysex length
					n_len = {25'd0, b[6:0]};
					n_skip = n_len;
					if (b[7]) n_ph = mtep_pkg::PH_SYSEX_LEN;
					else n_ph = (b[6:0] == 7'd0) ? mtep_pkg::PH_DELTA
						: mtep_pkg::PH_SYSEX_BODY;
					n_pay = b[7] ? pay_q : 24'd0;
				end else if (rs_q[7]) begin
					if (one_rs) begin
						ev = 1'b1; ch_a = b; ch_nd = 2'd1; n_ph = mtep_pkg::PH_DELTA;
						n_skip = 32'd1;
					end else begin
						n_held = b; n_skip = 32'd1; n_ph = mtep_pkg::PH_CH_DATA;
					end
				end else begin
					erf = 1'b1; ecode = mtep_pkg::E_NO_STATUS;
				end
			end
			mtep_pkg::PH_META_TYPE: begin
				n_meta = b; n_len = 32'd0; n_ph = mtep_pkg::PH_META_LEN;
			end
			mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
				n_len = lacc;
				if (!b[7]) begin
					n_pay = 24'd0;
					n_skip = lacc;
					if (ph_q == mtep_pkg::PH_META_LEN) begin
						if (lacc == 32'd0) n_ph = mtep_pkg::PH_DELTA;
						else n_ph = mtep_pkg::PH_META_BODY;
					end else begin
						n_ph = (lacc == 32'd0) ? mtep_pkg::PH_DELTA
							: mtep_pkg::PH_SYSEX_BODY;
					end
				end
			end
			mtep_pkg::PH_META_BODY: begin
				n_pay = {pay_q[15:0], b};
				n_skip = skip_q - 32'd1;
				if (n_skip == 32'd0) n_ph = mtep_pkg::PH_DELTA;
			end
			mtep_pkg::PH_SYSEX_BODY: begin
				n_skip = skip_q - 32'd1;
				if (n_skip == 32'd0) n_ph = mtep_pkg::PH_DELTA;
			end
			mtep_pkg::PH_CH_DATA: begin
				if (one_rs) begin
					ev = 1'b1; ch_a = b; ch_nd = 2'd1; n_ph = mtep_pkg::PH_DELTA;
				end else if (skip_q == 32'd2) begin
					n_held = b; n_skip = 32'd1;
				end else begin
					ev = 1'b1; ch_a = held_q; ch_b = b; ch_nd = 2'd2;
					n_ph = mtep_pkg::PH_DELTA;
				end
			end
			default: n_ph = mtep_pkg::PH_DELTA;
		endcase
		// Meta completes: length zero from length phase, or last body byte
		if ((ph_q == mtep_pkg::PH_META_LEN && !b[7] && lacc == 32'd0) ||
			(ph_q == mtep_pkg::PH_META_BODY && n_skip == 32'd0)) begin
			if (meta_q == 8'h51 && len_q == 32'd3 && ph_q == mtep_pkg::PH_META_BODY) begin
				ev = 1'b1; ev_tempo = 1'b1;
			end else if (meta_q == 8'h2F) begin
				n_ended = 1'b1;
			end
		end
		if (ev && !ev_tempo && ch_st[7:4] == 4'hB) begin
			if (ch_a == 8'd99 && ch_b == 8'd20) ekind = mtep_pkg::K_LSTART;
			else if (ch_a == 8'd99 && ch_b == 8'd30) ekind = mtep_pkg::K_LEND;
			else if (ch_a == 8'd102) ekind = mtep_pkg::K_LCOUNT;
			else if (ch_a == 8'd90) ekind = mtep_pkg::K_HOOK;
		end
		fin_ph = n_ph;
	end

	// End-of-meta for end-of-track (no hashing)
	logic end_ev;
	assign end_ev = ((ph_q == mtep_pkg::PH_META_LEN && !b[7] && lacc == 32'd0) ||
		(ph_q == mtep_pkg::PH_META_BODY && n_skip == 32'd0)) && !ev_tempo &&
		(meta_q == 8'h2F);

	// Error at the end of the track, by phase left
	logic [3:0] tail_code;
	always_comb begin
		case (fin_ph)
			mtep_pkg::PH_DELTA:      tail_code = n_ended ? 4'd0 : mtep_pkg::E_NO_END;
			mtep_pkg::PH_DELTA_MORE: tail_code = mtep_pkg::E_DELTA;
			mtep_pkg::PH_EVENT:      tail_code = mtep_pkg::E_EVENT;
			mtep_pkg::PH_META_TYPE:  tail_code = mtep_pkg::E_META_TYPE;
			mtep_pkg::PH_META_LEN, mtep_pkg::PH_META_BODY: tail_code = mtep_pkg::E_META;
			mtep_pkg::PH_SYSEX_LEN, mtep_pkg::PH_SYSEX_BODY: tail_code = mtep_pkg::E_SYSEX;
			default:                 tail_code = mtep_pkg::E_CHANNEL;
		endcase
	end

	logic accept_in, accept_out;
	assign in_ready = (state_q == S_IDLE);
	assign accept_in = in_valid && in_ready;
	assign out_valid = (state_q == S_EMIT);
	assign accept_out = out_valid && out_ready;

	// Result slot after hashing is finished; digests filled for done
	always_comb begin
		out_data = r0_q;
		if (r0_q.kind == mtep_pkg::K_DONE) begin
			out_data.channel_digest = ch_dig;
			out_data.tempo_digest = tp_dig;
		end
	end

	// Hash requests; digests cleared once a track is over
	always_comb begin
		hreq.start = (state_q == S_HASH) && !hbusy && (hleft_q != 3'd0);
		hreq.sel_tempo = hsel_q;
		hreq.data = hbytes_q[55:48];
	end
	assign hclear = (state_q == S_WAIT) ||
		((state_q == S_EMIT) && accept_out && (cnt_q == 2'd1) && last_q);

	mtep_pkg::out_item_t e0, e1;
	logic [1:0] ecount;
	always_comb begin
		e0 = '0; e1 = '0; ecount = 2'd0;
		if (erf) begin
			e0.kind = mtep_pkg::K_ERROR; e0.error_code = ecode; ecount = 2'd1;
		end else begin
			if (ev && ev_tempo) begin
				e0.kind = mtep_pkg::K_TEMPO; e0.event_tick = tick_q;
				e0.tempo_value = n_pay; ecount = 2'd1;
			end else if (ev) begin
				e0.kind = ekind; e0.event_tick = n_tick; e0.status_byte = ch_st;
				e0.first_data = ch_a; e0.second_data = ch_b; e0.data_count = ch_nd;
				ecount = 2'd1;
			end else if (end_ev) begin
				e0.kind = mtep_pkg::K_END; e0.event_tick = tick_q; ecount = 2'd1;
			end
			if (in_data.is_last) begin
				if (ecount == 2'd1) begin
					e1.kind = (tail_code == 4'd0) ? mtep_pkg::K_DONE : mtep_pkg::K_ERROR;
					e1.error_code = tail_code;
					e1.last_of_run = 1'b1;
				end else begin
					e0.kind = (tail_code == 4'd0) ? mtep_pkg::K_DONE : mtep_pkg::K_ERROR;
					e0.error_code = tail_code;
				end
				ecount = ecount + 2'd1;
			end
		end
		if (ecount == 2'd1) e0.last_of_run = 1'b1;
	end

	// Sequencer and parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rs_q <= '0; tick_q <= '0; len_q <= '0; skip_q <= '0;
			ph_q <= mtep_pkg::PH_DELTA; meta_q <= '0; pay_q <= '0; held_q <= '0;
			ended_q <= 1'b0; err_q <= 1'b0;
			cnt_q <= '0; last_q <= 1'b0; hleft_q <= '0; hsel_q <= 1'b0;
			hbytes_q <= '0; r0_q <= '0; r1_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						last_q <= in_data.is_last;
						if (err_q) begin
							if (in_data.is_last) begin
								rs_q <= '0; tick_q <= '0; len_q <= '0; skip_q <= '0;
								ph_q <= mtep_pkg::PH_DELTA; meta_q <= '0; pay_q <= '0;
								held_q <= '0; ended_q <= 1'b0; err_q <= 1'b0;
								state_q <= S_WAIT;
							end
						end else begin
							rs_q <= n_rs; tick_q <= n_tick; len_q <= n_len;
							skip_q <= n_skip; ph_q <= n_ph; meta_q <= n_meta;
							pay_q <= n_pay; held_q <= n_held; ended_q <= n_ended;
							err_q <= erf || (in_data.is_last && tail_code != 4'd0);
							r0_q <= e0; r1_q <= e1; cnt_q <= ecount;
							hsel_q <= ev_tempo;
							if (ev_tempo) begin
								hbytes_q <= {tick_q[7:0], tick_q[15:8], tick_q[23:16],
									tick_q[31:24], n_pay[23:16], n_pay[15:8], n_pay[7:0]};
								hleft_q <= 3'd7;
							end else begin
								hbytes_q <= {n_tick[7:0], n_tick[15:8], n_tick[23:16],
									n_tick[31:24], ch_st, ch_a, ch_b};
								hleft_q <= (ch_nd == 2'd2) ? 3'd7 : 3'd6;
							end
							if (ev && !erf) state_q <= S_HASH;
							else if (ecount != 2'd0) state_q <= S_EMIT;
							else if (in_data.is_last) state_q <= S_WAIT;
						end
					end
				end
				S_HASH: begin
					if (hreq.start) begin
						hbytes_q <= {hbytes_q[47:0], 8'd0};
						hleft_q <= hleft_q - 3'd1;
					end else if (!hbusy && hleft_q == 3'd0) begin
						state_q <= S_EMIT;
					end
				end
				S_WAIT: begin
					// Clear digests after a finished track with no results
					state_q <= S_IDLE;
				end
				S_EMIT: begin
					if (accept_out) begin
						r0_q <= r1_q;
						cnt_q <= cnt_q - 2'd1;
						if (cnt_q == 2'd1) begin
							state_q <= S_IDLE;
							if (last_q) begin
								rs_q <= '0; tick_q <= '0; len_q <= '0; skip_q <= '0;
								ph_q <= mtep_pkg::PH_DELTA; meta_q <= '0; pay_q <= '0;
								held_q <= '0; ended_q <= 1'b0; err_q <= 1'b0;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// Never offer a result while the multiply unit is still working
	a_no_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !hbusy) else $error("result shown while hashing");
	// Input is never taken while results are pending
	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (cnt_q == 2'd0 || state_q == S_IDLE)) else $error("accept with results");
	// A pending result count is at most two
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cnt_q == 2'd1 || cnt_q == 2'd2)) else $error("bad result count");
`endif

endmodule
